### hw/rtl/uti_pkg.sv
package uti_pkg;

  // Table depth default and fixed field widths
  localparam int DEFAULT_TABLE_DEPTH = 1024;
  localparam int LEN_W  = 11;   // table_length register
  localparam int ADDR_W = 4;    // configuration byte address
  localparam int MAG_W  = 49;   // |index| in Q.16, up to 2^48
  localparam int IND_W  = 50;   // signed index in Q.16

  // Pipeline: index stages 0..3, table read stage 4, blend stages 5..8
  localparam int NUM_STAGES  = 9;
  localparam int MIN_LATENCY = NUM_STAGES - 1;

  // Request codes
  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_INTERP  = 2'd1;
  localparam logic [1:0] REQ_NEAREST = 2'd2;

  // Status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SHORT = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

  // Register indexes (word address bits)
  localparam logic [1:0] REG_X_MIN  = 2'd0;
  localparam logic [1:0] REG_SCALE  = 2'd1;
  localparam logic [1:0] REG_LENGTH = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [9:0]         entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] x_value;
  } uti_req_t;

  typedef struct packed {
    logic signed [31:0] y_value;
    logic [1:0]         status;
  } uti_rsp_t;

  // Request fields carried along the index pipeline
  typedef struct packed {
    logic [1:0]         req_type;
    logic [9:0]         entry_index;
    logic signed [31:0] entry_value;
  } uti_meta_t;

endpackage

### hw/rtl/uti_index.sv
module uti_index
  import uti_pkg::*;
(
  input  logic                    clk_i,
  input  logic [3:0]              load_i,
  input  uti_req_t                req_i,
  input  logic signed [31:0]      x_min_i,
  input  logic [31:0]             scale_i,
  output logic signed [IND_W-1:0] ind_o,
  output uti_meta_t               meta_o
);

  uti_req_t                s0_q;
  uti_meta_t               meta0;
  uti_meta_t               meta1_q, meta2_q, meta3_q;
  logic signed [32:0]      diff;
  logic [32:0]             m_d, m_q;
  logic                    neg1_q, neg2_q;
  logic [MAG_W-1:0]        ph_d, pl_d, ph_q, pl_q;
  logic [MAG_W-1:0]        mag;
  logic signed [IND_W-1:0] ind_d, ind_q;

  assign meta0 = '{req_type:    s0_q.req_type,
                   entry_index: s0_q.entry_index,
                   entry_value: s0_q.entry_value};

  // Distance from x_min as sign and magnitude
  assign diff = {s0_q.x_value[31], s0_q.x_value} - {x_min_i[31], x_min_i};
  assign m_d  = diff[32] ? 33'(-diff) : 33'(diff);

  // Split scale into integer and fraction halves
  assign ph_d = MAG_W'(m_q) * MAG_W'(scale_i[31:16]);
  assign pl_d = MAG_W'(m_q) * MAG_W'(scale_i[15:0]);

  assign mag   = ph_q + (pl_q >> 16);
  assign ind_d = neg2_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      s0_q <= req_i;
    end
    if (load_i[1]) begin
      m_q     <= m_d;
      neg1_q  <= diff[32];
      meta1_q <= meta0;
    end
    if (load_i[2]) begin
      ph_q    <= ph_d;
      pl_q    <= pl_d;
      neg2_q  <= neg1_q;
      meta2_q <= meta1_q;
    end
    if (load_i[3]) begin
      ind_q   <= ind_d;
      meta3_q <= meta2_q;
    end
  end

  assign ind_o  = ind_q;
  assign meta_o = meta3_q;

endmodule

### hw/rtl/uti_table.sv
module uti_table
  import uti_pkg::*;
#(
  parameter int DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic                    clk_i,
  input  logic                    load_i,
  input  logic signed [IND_W-1:0] ind_i,
  input  uti_meta_t               meta_i,
  input  logic [LEN_W-1:0]        table_length_i,
  output logic signed [31:0]      y0_o,
  output logic signed [31:0]      y1_o,
  output logic signed [IND_W-1:0] frac_o,
  output logic [1:0]              req_o,
  output logic                    short_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int IW = IND_W - 16;

  logic [31:0]             table_mem_q [DEPTH];
  logic [LEN_W-1:0]        len;
  logic signed [IW-1:0]    len_s, lm1, lm2, ind_int, b_sel, n_sel;
  logic signed [IND_W-1:0] top, frac_d;
  logic                    is_interp, is_nearest, hi_clip, short_d, wr_en;
  logic [AW-1:0]           ra0, ra1, waddr;
  logic signed [31:0]      y0_q, y1_q;
  logic signed [IND_W-1:0] frac_q;
  logic [1:0]              req_q;
  logic                    short_q;

  assign len = (32'(table_length_i) > 32'(DEPTH)) ? LEN_W'(DEPTH) : table_length_i;

  assign len_s   = $signed({{(IW-LEN_W){1'b0}}, len});
  assign lm1     = len_s - IW'(1);
  assign lm2     = len_s - IW'(2);
  assign ind_int = ind_i[IND_W-1:16];
  assign top     = $signed({lm2, 16'b0});
  assign hi_clip = ind_int >= lm1;

  assign is_interp  = meta_i.req_type == REQ_INTERP;
  assign is_nearest = meta_i.req_type == REQ_NEAREST;
  assign short_d    = (is_interp && len < LEN_W'(2)) || (is_nearest && len == '0);

  // Base entry and fraction; outside the grid extrapolate from the end pair
  always_comb begin
    if (ind_i[IND_W-1]) begin
      b_sel  = '0;
      n_sel  = '0;
      frac_d = ind_i;
    end else if (hi_clip) begin
      b_sel  = lm2;
      n_sel  = lm1;
      frac_d = ind_i - top;
    end else begin
      b_sel  = ind_int;
      n_sel  = ind_int;
      frac_d = $signed({{(IND_W-16){1'b0}}, ind_i[15:0]});
    end
  end

  assign ra0   = is_interp ? AW'(b_sel) : AW'(n_sel);
  assign ra1   = is_interp ? AW'(b_sel + IW'(1)) : ra0;
  assign waddr = AW'(meta_i.entry_index);
  assign wr_en = load_i && meta_i.req_type == REQ_WRITE &&
                 32'(meta_i.entry_index) < 32'(DEPTH);

  // Reads and writes share this one stage, so a later query always sees
  // every earlier write.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      y0_q    <= table_mem_q[ra0];
      y1_q    <= table_mem_q[ra1];
      frac_q  <= frac_d;
      req_q   <= meta_i.req_type;
      short_q <= short_d;
    end
    if (wr_en) begin
      table_mem_q[waddr] <= meta_i.entry_value;
    end
  end

  assign y0_o    = y0_q;
  assign y1_o    = y1_q;
  assign frac_o  = frac_q;
  assign req_o   = req_q;
  assign short_o = short_q;

endmodule

### hw/rtl/uti_blend.sv
module uti_blend
  import uti_pkg::*;
(
  input  logic                    clk_i,
  input  logic [3:0]              load_i,
  input  logic signed [31:0]      y0_i,
  input  logic signed [31:0]      y1_i,
  input  logic signed [IND_W-1:0] frac_i,
  input  logic [1:0]              req_i,
  input  logic                    short_i,
  output uti_rsp_t                rsp_o
);

  localparam logic [65:0]        SAT_LIMIT = 66'(1) << 40;
  localparam logic signed [42:0] Y_MAX     = 43'sd2147483647;
  localparam logic signed [42:0] Y_MIN     = -43'sd2147483648;

  logic signed [32:0]  delta;
  logic [32:0]         dm_d, dm_q;
  logic [MAG_W-1:0]    fm_d, fm_q;
  logic [49:0]         qhi_d, qhi_q;
  logic [48:0]         qlo_d, qlo_q, qfl_d, qfl_q;
  logic [65:0]         prod;
  logic [41:0]         mag_d, mag_q;
  logic                neg5_q, neg6_q, neg7_q, sat_d, sat_q;
  logic signed [31:0]  base5_q, base6_q, base7_q;
  logic [1:0]          req5_q, req6_q, req7_q;
  logic                short5_q, short6_q, short7_q;
  logic signed [42:0]  base_x, mag_s, sum;
  uti_rsp_t            rsp_d, rsp_q;

  assign delta = {y1_i[31], y1_i} - {y0_i[31], y0_i};
  assign dm_d  = delta[32] ? 33'(-delta) : 33'(delta);
  assign fm_d  = MAG_W'(frac_i[IND_W-1] ? -frac_i : frac_i);

  assign qhi_d = 50'(fm_q[48:32]) * 50'(dm_q);
  assign qlo_d = 49'(fm_q[31:16]) * 49'(dm_q);
  assign qfl_d = 49'(fm_q[15:0]) * 49'(dm_q);

  assign prod  = (66'(qhi_q) << 16) + 66'(qlo_q);
  assign sat_d = prod > SAT_LIMIT;
  assign mag_d = 42'(prod) + 42'(qfl_q >> 16);

  assign base_x = $signed({{11{base7_q[31]}}, base7_q});
  assign mag_s  = $signed({1'b0, mag_q});
  assign sum    = base_x + (neg7_q ? -mag_s : mag_s);

  always_comb begin
    rsp_d.y_value = '0;
    rsp_d.status  = STATUS_OK;
    if (short7_q) begin
      rsp_d.status = STATUS_SHORT;
    end else if (req7_q == REQ_INTERP) begin
      if (sat_q || sum > Y_MAX || sum < Y_MIN) begin
        rsp_d.status = STATUS_SAT;
        if (sat_q ? neg7_q : sum < Y_MIN) begin
          rsp_d.y_value = 32'sh80000000;
        end else begin
          rsp_d.y_value = 32'sh7fffffff;
        end
      end else begin
        rsp_d.y_value = 32'(sum);
      end
    end else if (req7_q == REQ_NEAREST) begin
      rsp_d.y_value = base7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i[0]) begin
      fm_q     <= fm_d;
      dm_q     <= dm_d;
      neg5_q   <= frac_i[IND_W-1] ^ delta[32];
      base5_q  <= y0_i;
      req5_q   <= req_i;
      short5_q <= short_i;
    end
    if (load_i[1]) begin
      qhi_q    <= qhi_d;
      qlo_q    <= qlo_d;
      qfl_q    <= qfl_d;
      neg6_q   <= neg5_q;
      base6_q  <= base5_q;
      req6_q   <= req5_q;
      short6_q <= short5_q;
    end
    if (load_i[2]) begin
      mag_q    <= mag_d;
      sat_q    <= sat_d;
      neg7_q   <= neg6_q;
      base7_q  <= base6_q;
      req7_q   <= req6_q;
      short7_q <= short6_q;
    end
    if (load_i[3]) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

### hw/rtl/uniform_table_linear_interpolator_unit.sv
// Uniform-grid lookup table with linear interpolation, Q16.16 fixed point.
// Request channel (in_valid_i/in_ready_o, in_data_i): a write request loads
// one table entry; an interpolate or nearest request looks up x_value and
// returns y_value with a status. Every request, writes too, yields exactly
// one response on the response channel (out_valid_o/out_ready_i, out_data_o),
// in request order.
// Throughput: one request per cycle while the response channel is not
// stalled. Nine pipeline stages: four for the index (input register,
// distance, multiply, sum), one for the table RAM (two read ports and the
// write port, all in the same stage), three for the blend multiply and sum,
// and the output register, which also saturates.
// Stall: each stage carries its own valid bit, so bubbles close up and
// requests are still taken while a response waits; up to nine requests are
// held before in_ready_o drops.
// Reset: config registers clear to zero and the pipeline empties. The table
// RAM is not cleared; load every entry a query reaches before using it.
// Config: APB, x_min at 0x0, scale_factor at 0x4, table_length at 0x8.
// Write config only while the pipeline is empty.
module uniform_table_linear_interpolator_unit
  import uti_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  uti_req_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output uti_rsp_t          out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [NUM_STAGES-1:0]   valid_d, valid_q;
  logic [NUM_STAGES-1:0]   adv;
  logic [NUM_STAGES-1:0]   load;
  logic                    in_xfer;
  logic                    cfg_wr;

  logic signed [31:0]      x_min_d, x_min_q;
  logic [31:0]             scale_d, scale_q;
  logic [LEN_W-1:0]        length_d, length_q;

  logic signed [IND_W-1:0] ind;
  uti_meta_t               meta;
  logic signed [31:0]      y0, y1;
  logic signed [IND_W-1:0] frac;
  logic [1:0]              req;
  logic                    short;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    x_min_d  = x_min_q;
    scale_d  = scale_q;
    length_d = length_q;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_X_MIN:  x_min_d  = pwdata;
        REG_SCALE:  scale_d  = pwdata;
        REG_LENGTH: length_d = pwdata[LEN_W-1:0];
        default:    ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_X_MIN:  prdata = x_min_q;
      REG_SCALE:  prdata = scale_q;
      REG_LENGTH: prdata = 32'(length_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q  <= '0;
      scale_q  <= '0;
      length_q <= '0;
    end else begin
      x_min_q  <= x_min_d;
      scale_q  <= scale_d;
      length_q <= length_d;
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control: a stage advances when the next one is empty or
  // advancing itself; the last stage is the output register.
  // ---------------------------------------------------------------------
  always_comb begin
    adv[NUM_STAGES-1] = valid_q[NUM_STAGES-1] & out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = valid_q[k] & (~valid_q[k+1] | adv[k+1]);
    end
  end

  assign in_ready_o = ~valid_q[0] | adv[0];
  assign in_xfer    = in_valid_i & in_ready_o;
  assign load       = {adv[NUM_STAGES-2:0], in_xfer};
  assign valid_d    = load | (valid_q & ~adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // ---------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------
  uti_index u_index (
    .clk_i   (clk_i),
    .load_i  (load[3:0]),
    .req_i   (in_data_i),
    .x_min_i (x_min_q),
    .scale_i (scale_q),
    .ind_o   (ind),
    .meta_o  (meta)
  );

  uti_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i          (clk_i),
    .load_i         (load[4]),
    .ind_i          (ind),
    .meta_i         (meta),
    .table_length_i (length_q),
    .y0_o           (y0),
    .y1_o           (y1),
    .frac_o         (frac),
    .req_o          (req),
    .short_o        (short)
  );

  uti_blend u_blend (
    .clk_i   (clk_i),
    .load_i  (load[8:5]),
    .y0_i    (y0),
    .y1_i    (y1),
    .frac_i  (frac),
    .req_i   (req),
    .short_i (short),
    .rsp_o   (out_data_o)
  );

  assign out_valid_o = valid_q[NUM_STAGES-1];

endmodule

### hw/rtl/uti_checker.sv
module uti_checker
  import uti_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input uti_rsp_t          out_data_o,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [31:0]       pwdata,
  input logic [31:0]       prdata
);

  // Hold a stalled response
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("response changed while stalled");

  // An empty output register means the whole pipeline can move
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("request stalled with empty output");

  // A response that appears on an idle output went through without a stall
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, MIN_LATENCY + 1))
    else $error("response without matching request");

  // Read back the last scale_factor written
  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && paddr[3:2] == REG_SCALE
    ##1 paddr[3:2] == REG_SCALE && !pwrite |-> prdata == $past(pwdata))
    else $error("scale_factor read back wrong");

endmodule

bind uniform_table_linear_interpolator_unit uti_checker u_checker (.*);

### tb/uniform_table_linear_interpolator_unit_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the uniform-grid interpolator. A directed table
// walks the corner cases. Random phases then load the table, sweep queries
// and vary the grid registers. Every response is compared field by field
// against its typed answer or an in-bench lookup of the same fixed-point math.
module uniform_table_linear_interpolator_unit_tb;
  import uti_pkg::*;

  typedef longint unsigned u64_t;

  localparam int   DEPTH       = DEFAULT_TABLE_DEPTH;
  localparam int   CYCLE_LIMIT = 1_000_000;
  localparam int   NUM_PHASES  = 10;
  localparam int   PHASE_ITEMS = 70;
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam longint Y_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Y_MIN = 64'shFFFF_FFFF_8000_0000;

  // Directed rows: a register write or one request, with the response typed
  // in where it is obvious, else taken from the lookup below.
  localparam bit CFG = 1'b1, REQ = 1'b0;
  localparam bit TYPED = 1'b1, CALC = 1'b0;

  typedef struct packed {
    bit          cfg;
    logic [1:0]  code;
    logic [9:0]  idx;
    logic [31:0] val;
    logic [31:0] x;
    bit          typed;
    logic [31:0] y;
    logic [1:0]  st;
  } step_t;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  uti_req_t          in_data_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  uti_rsp_t          out_data_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [ADDR_W-1:0] paddr       = '0;
  logic [31:0]       pwdata      = '0;
  logic [31:0]       prdata;
  logic              pready;

  uniform_table_linear_interpolator_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Shadow of the block: grid registers and table contents.
  logic signed [31:0] cur_x_min  = '0;
  logic [31:0]        cur_scale  = '0;
  logic [10:0]        cur_length = '0;
  logic signed [31:0] y_table  [DEPTH];
  bit                 y_loaded [DEPTH];

  uti_rsp_t answers_due [$];
  uti_rsp_t due;

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int rx_hold   = 0;
  int rx_roll;
  int cycle     = 0;

  int n_mismatch = 0;
  int n_checked  = 0;
  int n_writes   = 0;
  int n_interp   = 0;
  int n_nearest  = 0;
  int n_sat      = 0;
  int n_short    = 0;
  int n_settings = 0;

  step_t plan [26];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Entries in use: table_length clamped to the table depth.
  function automatic int used_length();
    return (cur_length > DEPTH) ? DEPTH : int'(cur_length);
  endfunction

  // Response to one request; a write also updates the shadow table.
  function automatic uti_rsp_t lookup_result(uti_req_t r);
    uti_rsp_t res;
    longint   diff, ind, top, frac, base, delta, sum, smag;
    u64_t     m, fm, dm, fh, fl;
    bit       neg;
    int       len, b;
    res.y_value = '0;
    res.status  = STATUS_OK;
    len = used_length();
    // Q32.16 grid position, magnitude truncated toward zero
    diff = longint'(r.x_value) - longint'(cur_x_min);
    m = (diff < 0) ? u64_t'(-diff) : u64_t'(diff);
    m = m * u64_t'(cur_scale[31:16]) + ((m * u64_t'(cur_scale[15:0])) >> 16);
    ind = (diff < 0) ? -longint'(m) : longint'(m);
    case (r.req_type)
      REQ_WRITE: begin
        y_table[r.entry_index]  = r.entry_value;
        y_loaded[r.entry_index] = 1'b1;
      end
      REQ_INTERP: begin
        if (len < 2) begin
          res.status = STATUS_SHORT;
        end else begin
          // Outside the grid, extend the first or last segment.
          top = longint'(len - 2) << 16;
          if (ind < 0) begin
            b = 0;
            frac = ind;
          end else if (ind > top) begin
            b = len - 2;
            frac = ind - top;
          end else begin
            b = int'(ind >>> 16);
            frac = ind & 64'hFFFF;
          end
          base  = longint'(y_table[b]);
          delta = longint'(y_table[b + 1]) - base;
          fm  = (frac < 0) ? u64_t'(-frac) : u64_t'(frac);
          dm  = (delta < 0) ? u64_t'(-delta) : u64_t'(delta);
          neg = (frac < 0) != (delta < 0);
          fh  = fm >> 16;
          fl  = fm & 64'hFFFF;
          if (fm == 0 || dm == 0) begin
            sum = base;
          end else if (fh != 0 && dm > (u64_t'(1) << 40) / fh) begin
            // product alone is past any 32-bit result
            sum = neg ? Y_MIN - 1 : Y_MAX + 1;
          end else begin
            smag = longint'(fh * dm + ((fl * dm) >> 16));
            sum = neg ? base - smag : base + smag;
          end
          if (sum > Y_MAX) begin
            res.y_value = Y_MAX[31:0];
            res.status  = STATUS_SAT;
          end else if (sum < Y_MIN) begin
            res.y_value = Y_MIN[31:0];
            res.status  = STATUS_SAT;
          end else begin
            res.y_value = sum[31:0];
          end
        end
      end
      REQ_NEAREST: begin
        if (len < 1) begin
          res.status = STATUS_SHORT;
        end else begin
          top = longint'(len - 1) << 16;
          if (ind < 0) ind = 0;
          if (ind > top) ind = top;
          res.y_value = y_table[int'(ind >>> 16)];
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Mostly modest y values so interior blends stay in range, plus full-range values and extremes.
  function automatic logic [31:0] random_y();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
    endcase
  endfunction

  // Aim most queries a little below, across and a little above the grid.
  function automatic logic [31:0] random_x();
    longint span, off;
    u64_t   roll;
    if (cur_scale == 0 || $urandom_range(0, 4) == 0) return $urandom;
    span = ((longint'(used_length()) + 1) << 32) / longint'(cur_scale);
    if (span > (longint'(1) << 33)) span = longint'(1) << 33;
    roll = {$urandom, $urandom};
    off = longint'(roll % u64_t'(span + span / 2 + 1)) - span / 4;
    return cur_x_min + off[31:0];
  endfunction

  function automatic uti_req_t random_request();
    uti_req_t r;
    int       roll;
    r.entry_index = 10'($urandom);
    r.entry_value = random_y();
    r.x_value     = random_x();
    roll = $urandom_range(0, 99);
    if (roll < 12)      r.req_type = REQ_WRITE;
    else if (roll < 16) r.req_type = REQ_UNUSED;
    else if (roll < 58) r.req_type = REQ_INTERP;
    else                r.req_type = REQ_NEAREST;
    return r;
  endfunction

  // Sender gap: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (tx_steady || roll < 55) return 0;
    if (roll < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(string what);
    n_mismatch++;
    if (n_mismatch <= 30)
      $display("[%0t] mismatch on response %0d: %s", $time, n_checked, what);
  endtask

  // Present one request, hold it until the transfer, then queue its answer.
  task automatic send_item(uti_req_t r, bit typed, uti_rsp_t want);
    uti_rsp_t got;
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    do @(posedge clk_i); while (!in_ready_o);
    got = lookup_result(r);
    if (typed) got = want;
    answers_due = {answers_due, got};
    case (r.req_type)
      REQ_WRITE:   n_writes++;
      REQ_INTERP:  n_interp++;
      REQ_NEAREST: n_nearest++;
      default: ;
    endcase
  endtask

  // Drop valid only for a real gap, so back-to-back transfers keep it high.
  task automatic pause(int n);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Hold off the sender until every queued response has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
  endtask

  // APB write: setup, access, then idle with psel low.
  task automatic write_reg(logic [1:0] sel, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (sel)
      REG_X_MIN:  cur_x_min  = data;
      REG_SCALE:  cur_scale  = data;
      REG_LENGTH: cur_length = data[10:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Receiver: stall at random, mostly briefly, sometimes for a long stretch.
  always @(posedge clk_i) begin
    if (rx_steady) begin
      out_ready_i <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_ready_i <= 1'b0;
    end else begin
      rx_roll = $urandom_range(0, 99);
      if (rx_roll < 65) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        rx_hold = (rx_roll < 96) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      end
    end
  end

  // Check each response transfer against the oldest queued answer.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      n_checked++;
      if (answers_due.size() == 0) begin
        report_mismatch("response with nothing outstanding");
      end else begin
        due = answers_due.pop_front();
        if (due.status == STATUS_SAT)   n_sat++;
        if (due.status == STATUS_SHORT) n_short++;
        if (out_data_o.y_value !== due.y_value)
          report_mismatch($sformatf("y_value %h, want %h", out_data_o.y_value, due.y_value));
        if (out_data_o.status !== due.status)
          report_mismatch($sformatf("status %0d, want %0d", out_data_o.status, due.status));
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle++;
    if (cycle >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle, answers_due.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    uti_req_t    req;
    uti_rsp_t    want;
    logic [31:0] xm, sc;
    logic [10:0] len_set;

    plan = '{
      // registers at reset: table empty, so queries report a short table
      '{REQ, REQ_INTERP,  10'd0,   32'h0,         32'h0000_0000, TYPED, 32'h0, STATUS_SHORT},
      '{REQ, REQ_NEAREST, 10'd0,   32'h0,         32'h7FFF_FFFF, TYPED, 32'h0, STATUS_SHORT},
      '{REQ, REQ_UNUSED,  10'h3FF, 32'hFFFF_FFFF, 32'h8000_0000, TYPED, 32'h0, STATUS_OK},
      // load extremes at both ends of the index range
      '{REQ, REQ_WRITE,   10'd0,   32'h7FFF_FFFF, 32'h0,         TYPED, 32'h0, STATUS_OK},
      '{REQ, REQ_WRITE,   10'd1,   32'h8000_0000, 32'h0,         TYPED, 32'h0, STATUS_OK},
      '{REQ, REQ_WRITE,   10'd2,   32'h0001_0000, 32'h0,         TYPED, 32'h0, STATUS_OK},
      '{REQ, REQ_WRITE,   10'h3FF, 32'h0000_1234, 32'hFFFF_FFFF, TYPED, 32'h0, STATUS_OK},
      // one entry: interpolation is short, nearest returns entry zero
      '{CFG, REG_LENGTH,  10'd0,   32'd1,         32'h0,         CALC,  32'h0, STATUS_OK},
      '{REQ, REQ_INTERP,  10'd0,   32'h0,         32'h0000_1234, TYPED, 32'h0, STATUS_SHORT},
      '{REQ, REQ_NEAREST, 10'd0,   32'h0,         32'h8000_0000, TYPED, 32'h7FFF_FFFF,
        STATUS_OK},
      // unit step, three entries
      '{CFG, REG_SCALE,   10'd0,   32'h0001_0000, 32'h0,         CALC,  32'h0, STATUS_OK},
      '{CFG, REG_LENGTH,  10'd0,   32'd3,         32'h0,         CALC,  32'h0, STATUS_OK},
      '{REQ, REQ_INTERP,  10'd0,   32'h0,         32'h0000_0000, TYPED, 32'h7FFF_FFFF,
        STATUS_OK},
      '{REQ, REQ_INTERP,  10'd0,   32'h0,         32'h0000_8000, CALC,  32'h0, STATUS_OK},
      // extrapolation past either end saturates high
      '{REQ, REQ_INTERP,  10'd0,   32'h0,         32'hFFFF_0000, TYPED, 32'h7FFF_FFFF,
        STATUS_SAT},
      '{REQ, REQ_INTERP,  10'd0,   32'h0,         32'h7FFF_FFFF, TYPED, 32'h7FFF_FFFF,
        STATUS_SAT},
      // nearest clamps at both ends and truncates in between
      '{REQ, REQ_NEAREST, 10'd0,   32'h0,         32'h8000_0000, TYPED, 32'h7FFF_FFFF,
        STATUS_OK},
      '{REQ, REQ_NEAREST, 10'd0,   32'h0,         32'h0001_8000, TYPED, 32'h8000_0000,
        STATUS_OK},
      '{REQ, REQ_NEAREST, 10'd0,   32'h0,         32'h7FFF_FFFF, TYPED, 32'h0001_0000,
        STATUS_OK},
      // x_min at both extremes gives the widest x distance
      '{CFG, REG_X_MIN,   10'd0,   32'h8000_0000, 32'h0,         CALC,  32'h0, STATUS_OK},
      '{REQ, REQ_INTERP,  10'd0,   32'h0,         32'h7FFF_FFFF, CALC,  32'h0, STATUS_OK},
      '{CFG, REG_X_MIN,   10'd0,   32'h7FFF_FFFF, 32'h0,         CALC,  32'h0, STATUS_OK},
      '{REQ, REQ_INTERP,  10'd0,   32'h0,         32'h8000_0000, CALC,  32'h0, STATUS_OK},
      // rising first segment extrapolated far below saturates low
      '{REQ, REQ_WRITE,   10'd0,   32'h8000_0000, 32'h0,         TYPED, 32'h0, STATUS_OK},
      '{REQ, REQ_WRITE,   10'd1,   32'h0000_0000, 32'h0,         TYPED, 32'h0, STATUS_OK},
      '{REQ, REQ_INTERP,  10'd0,   32'h0,         32'h8000_0000, TYPED, 32'h8000_0000,
        STATUS_SAT}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: register rows only once the pipeline is empty.
    foreach (plan[k]) begin
      if (plan[k].cfg) begin
        drain();
        write_reg(plan[k].code, plan[k].val);
      end else begin
        req  = '{plan[k].code, plan[k].idx, plan[k].val, plan[k].x};
        want = '{plan[k].y, plan[k].st};
        send_item(req, plan[k].typed, want);
        pause(pick_gap());
      end
    end

    // Random phases, each with its own grid setting.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      xm = $urandom;
      sc = $urandom;
      case (ph)
        0: begin len_set = 11'd2;    xm = 32'h0; sc = 32'h0001_0000; end
        1: begin len_set = 11'd8;    sc = $urandom_range(32'h1000, 32'h8_0000); end
        2: begin len_set = 11'd16;   xm = 32'h8000_0000; sc = 32'hFFFF_FFFF; end
        3: len_set = 11'd1;
        4: len_set = 11'd0;
        5: len_set = 11'd40;
        6: begin len_set = 11'd1024; sc = $urandom_range(32'h100, 32'h10_0000); end
        7: begin len_set = 11'd2047; sc = $urandom_range(1, 32'h4_0000); end
        8: begin len_set = 11'd5;    xm = 32'h7FFF_FFFF; sc = 32'h0; end
        default: len_set = 11'($urandom_range(2, 64));
      endcase
      // first phase runs with no idling at all on either side
      tx_steady = (ph == 0) || ($urandom_range(0, 3) == 0);
      rx_steady = (ph == 0) || ($urandom_range(0, 3) == 0);
      drain();
      write_reg(REG_X_MIN, xm);
      write_reg(REG_SCALE, sc);
      write_reg(REG_LENGTH, {21'b0, len_set});
      n_settings++;

      // Load every entry a query can reach before asking anything.
      for (int i = 0; i < used_length(); i++) begin
        if (!y_loaded[i]) begin
          req = '{REQ_WRITE, 10'(i), random_y(), 32'($urandom)};
          send_item(req, CALC, '0);
          pause(pick_gap());
        end
      end

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // now and then let the pipeline run dry mid-phase
        if (i == PHASE_ITEMS / 2 && ph % 3 == 1) drain();
        send_item(random_request(), CALC, '0);
        pause(pick_gap());
      end
    end

    drain();
    repeat (2 * MIN_LATENCY) @(posedge clk_i);

    $display("run: %0d writes, %0d interpolations, %0d nearest lookups over %0d grid settings",
             n_writes, n_interp, n_nearest, n_settings);
    $display("run: %0d responses checked, %0d saturated, %0d short table, %0d mismatches",
             n_checked, n_sat, n_short, n_mismatch);
    if (n_mismatch == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/uti_pkg.sv
hw/rtl/uti_index.sv
hw/rtl/uti_table.sv
hw/rtl/uti_blend.sv
hw/rtl/uniform_table_linear_interpolator_unit.sv
hw/rtl/uti_checker.sv
tb/uniform_table_linear_interpolator_unit_tb.sv
